[design/bfa_pkg.sv]
// Shared types and constants for the bitmap first-free allocator.
package bfa_pkg;

	localparam int IDX_W    = 10;
	localparam int CFG_W    = 11;
	localparam int STATUS_W = 2;
	localparam int CMD_W    = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_MARK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Verdict of the scan unit on one bitmap word.
	typedef struct packed {
		logic             hit;
		logic             wr_en;
		status_t          status;
		logic [IDX_W-1:0] granted;
	} scan_res_t;

endpackage

[design/bfa_req_if.sv]
// Request channel: command and entry index.
interface bfa_req_if import bfa_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] entry_index;

	modport source (output valid, cmd, entry_index, input ready);
	modport sink   (input valid, cmd, entry_index, output ready);
endinterface

[design/bfa_rsp_if.sv]
// Response channel: granted index and status.
interface bfa_rsp_if import bfa_pkg::*;;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    granted_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, granted_index, status, input ready);
	modport sink   (input valid, granted_index, status, output ready);
endinterface

[design/bfa_bitmap_mem.sv]
// Bitmap word memory with per-word valid bits; unwritten words read as all free.
module bfa_bitmap_mem import bfa_pkg::*; #(
	parameter int NUM_WORDS = 32,
	parameter int WORD_BITS = 32,
	parameter int AW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/bfa_scan_unit.sv]
// Shared word evaluator: lowest clear bit for allocate, bit locate for free/mark.
module bfa_scan_unit import bfa_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int LW        = 11
) (
	input  cmd_t                 cmd,
	input  logic [IDX_W-1:0]     idx,
	input  logic [LW-1:0]        limit,
	input  logic [LW-1:0]        base,
	input  logic [WORD_BITS-1:0] word,
	output scan_res_t            res,
	output logic [WORD_BITS-1:0] new_word
);

	localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	logic                 fz_found;
	logic [BW-1:0]        fz;
	logic [LW-1:0]        e;
	logic [LW-1:0]        idx_ext;
	logic [LW-1:0]        top;
	logic [LW-1:0]        off_full;
	logic [BW-1:0]        sel;
	logic [WORD_BITS-1:0] mask;

	// priority encoder, lowest clear bit wins
	always_comb begin
		fz_found = 1'b0;
		fz       = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				fz_found = 1'b1;
				fz       = BW'(i);
			end
		end
	end

	assign e        = base + LW'(fz);
	assign idx_ext  = LW'(idx);
	assign top      = base + LW'(WORD_BITS);
	assign off_full = idx_ext - base;
	assign sel      = (cmd == CMD_ALLOC) ? fz : off_full[BW-1:0];
	assign mask     = WORD_BITS'(1) << sel;

	always_comb begin
		res.hit     = 1'b0;
		res.wr_en   = 1'b0;
		res.status  = ST_OK;
		res.granted = '0;
		new_word    = word;
		case (cmd)
			CMD_ALLOC: begin
				if (fz_found) begin
					res.hit = 1'b1;
					if (e < limit) begin
						res.wr_en   = 1'b1;
						res.granted = e[IDX_W-1:0];
						new_word    = word | mask;
					end else begin
						res.status = ST_FULL;
					end
				end
			end
			CMD_FREE, CMD_MARK: begin
				if (idx_ext < top) begin
					res.hit     = 1'b1;
					res.wr_en   = 1'b1;
					res.granted = idx;
					new_word    = (cmd == CMD_MARK) ? (word | mask) : (word & ~mask);
				end
			end
			default: begin
				res.hit = 1'b0;
			end
		endcase
	end

endmodule

[design/bitmap_first_free_allocator_top.sv]
// Top level of the bitmap first-free allocator: sequencer, config and response register.
//
// Usage:
//   req (sink): cmd and entry_index. Allocate grants the lowest free entry below the
//     active count (entries_in_use capped at MAX_ENTRIES); free clears, mark sets.
//   rsp (source): granted_index and status (ok / full / out of range), one beat per
//     request beat, in order.
//   cfg_we / cfg_wdata: writes entries_in_use; only while no request is in flight.
// Timing:
//   One request at a time; req.ready is high only in the idle state. The bitmap
//   memory is read one word per cycle and each word goes through a single shared
//   scan unit, so allocate reads from word 0 up to the first word with a clear bit,
//   free/mark up to the word that holds the index; out-of-range and the unused
//   command skip the scan and go straight to the result.
// Reset:
//   arst_n clears all word valid bits, so the whole bitmap reads free at once;
//   no clearing pass. entries_in_use returns to 1024.
// Backpressure:
//   The result waits in an output register; the next request is still accepted,
//   and a finished result holds the sequencer until that register drains.
module bitmap_first_free_allocator_top import bfa_pkg::*; #(
	parameter int MAX_ENTRIES = 1024,
	parameter int WORD_BITS   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	bfa_req_if.sink          req,
	bfa_rsp_if.source        rsp
);

	localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int WCW       = $clog2(NUM_WORDS + 1);
	localparam int LW_RAW    = $clog2(MAX_ENTRIES + WORD_BITS + 1);
	localparam int LW        = (LW_RAW > CFG_W) ? LW_RAW : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	cmd_t                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WCW-1:0]       word_q;     // next word to read
	logic [LW-1:0]        base_q;     // entry number of bit 0 of word_q
	logic                 pend_s1;    // a read was issued last cycle
	logic [AW-1:0]        word_s1;
	logic [LW-1:0]        base_s1;
	status_t              res_status_q;
	logic [IDX_W-1:0]     res_granted_q;
	logic                 rsp_valid_q;
	logic [IDX_W-1:0]     rsp_granted_q;
	status_t              rsp_status_q;

	logic [LW-1:0]        limit;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] new_word;
	scan_res_t            scan_res;
	logic                 hit;
	logic                 words_left;
	logic                 mem_re;
	logic                 mem_we;
	logic                 rsp_free;
	cmd_t                 req_cmd;

	// active count: register capped at the physical size
	assign limit = (LW'(cfg_q) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(cfg_q);

	assign req_cmd    = cmd_t'(req.cmd);
	assign hit        = pend_s1 && scan_res.hit;
	assign words_left = (word_q < WCW'(NUM_WORDS));
	assign mem_re     = (state_q == S_SCAN) && !hit && words_left;
	assign mem_we     = (state_q == S_SCAN) && hit && scan_res.wr_en;
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	bfa_bitmap_mem #(
		.NUM_WORDS (NUM_WORDS),
		.WORD_BITS (WORD_BITS),
		.AW        (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_re),
		.rd_addr (word_q[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (word_s1),
		.wr_data (new_word)
	);

	bfa_scan_unit #(
		.WORD_BITS (WORD_BITS),
		.LW        (LW)
	) u_scan (
		.cmd      (cmd_q),
		.idx      (idx_q),
		.limit    (limit),
		.base     (base_s1),
		.word     (rd_data),
		.res      (scan_res),
		.new_word (new_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_s1     <= 1'b0;
			word_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop the beat once taken
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						word_q  <= '0;
						pend_s1 <= 1'b0;
						case (req_cmd)
							CMD_ALLOC: begin
								state_q <= S_SCAN;
							end
							CMD_FREE, CMD_MARK: begin
								if (LW'(req.entry_index) >= limit) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (words_left) begin
						pend_s1 <= 1'b1;
						word_q  <= word_q + WCW'(1);
					end else if (!pend_s1) begin
						// every word full
						state_q <= S_DONE;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q  <= req_cmd;
				idx_q  <= req.entry_index;
				base_q <= '0;
				if ((req_cmd == CMD_FREE || req_cmd == CMD_MARK)
						&& LW'(req.entry_index) >= limit) begin
					res_status_q  <= ST_RANGE;
					res_granted_q <= '0;
				end else begin
					res_status_q  <= ST_OK;
					res_granted_q <= req.entry_index;
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_status_q  <= scan_res.status;
					res_granted_q <= scan_res.granted;
				end else if (words_left) begin
					word_s1 <= word_q[AW-1:0];
					base_s1 <= base_q;
					base_q  <= base_q + LW'(WORD_BITS);
				end else begin
					res_status_q  <= ST_FULL;
					res_granted_q <= '0;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_status_q  <= res_status_q;
					rsp_granted_q <= res_granted_q;
				end
			end
			default: begin
				res_status_q <= ST_OK;
			end
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.granted_index = rsp_granted_q;
	assign rsp.status        = rsp_status_q;

	a_we_only_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN) && pend_s1)
		else $error("bitmap write outside a scan hit");

	a_we_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == S_DONE))
		else $error("write not followed by result");

	a_word_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_q <= WCW'(NUM_WORDS))
		else $error("word counter ran past the bitmap");

	a_err_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_RANGE)
			|-> rsp.granted_index == '0)
		else $error("error result with nonzero index");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !rsp_free |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

[verif/tb.sv]
// Self-checking testbench for the bitmap first-free allocator top level.
`timescale 1ns / 1ps

module tb;
	import bfa_pkg::*;

	localparam int MAX_ENTRIES = 1024;
	localparam int WORD_BITS   = 32;
	localparam int NUM_WORDS   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;

	// Stimulus size and run guards.
	localparam int ITEM_TARGET  = 1050;
	localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
	localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 40;    // longer than the longest allocate scan
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		cmd_t             op;
		logic [IDX_W-1:0] index;
	} request_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted;
		status_t          status;
	} grant_t;

	bit               clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	bfa_req_if req_ch ();
	bfa_rsp_if rsp_ch ();

	bitmap_first_free_allocator_top #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WORD_BITS   (WORD_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the allocator: usage bitmap plus the entry-limit register.
	// A set bit means the entry is in use.
	// ------------------------------------------------------------------
	logic [WORD_BITS-1:0] used_map [NUM_WORDS] = '{default: '0};
	logic [CFG_W-1:0]     entry_limit = CFG_RESET;

	request_t request_backlog [$];  // filled by the sequencer, drained by the driver
	grant_t   expected_grants [$];  // one per accepted request beat, in order

	int n_queued     = 0;
	int n_accepted   = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_cfg_writes = 0;
	int n_by_cmd [4] = '{default: 0};
	int n_by_status [4] = '{default: 0};

	// Receiver hold-off request, raised once by the sequencer.
	logic hold_req    = 1'b0;
	int   hold_cycles = 0;

	int  issue_gap   = 0;
	int  stall_left  = 0;
	bit  send_quiet  = 1'b0;
	bit  recv_quiet  = 1'b0;
	int  idle_cycles = 0;

	// Limit is capped at the table size; values above it behave as full size.
	function automatic int active_entries();
		return (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_limit);
	endfunction

	// Applies one command to the shadow bitmap and returns the expected beat.
	function automatic grant_t predict_grant(cmd_t op, logic [IDX_W-1:0] idx);
		grant_t res;
		int     act;
		int     e;
		bit     done;
		bit     found;
		res.granted = '0;
		res.status  = ST_OK;
		act         = active_entries();
		case (op)
			CMD_ALLOC: begin
				// First non-full word, lowest clear bit; stop at the limit.
				done  = 1'b0;
				found = 1'b0;
				for (int w = 0; w < NUM_WORDS && !done; w++) begin
					if (!(&used_map[w])) begin
						for (int b = 0; b < WORD_BITS && !done; b++) begin
							e = w * WORD_BITS + b;
							if (e >= act) begin
								done = 1'b1;
							end else if (!used_map[w][b]) begin
								done           = 1'b1;
								found          = 1'b1;
								used_map[w][b] = 1'b1;
								res.granted    = e[IDX_W-1:0];
							end
						end
					end
				end
				if (!found)
					res.status = ST_FULL;
			end
			CMD_FREE, CMD_MARK: begin
				if (int'(idx) >= act) begin
					res.status = ST_RANGE;
				end else begin
					used_map[idx / WORD_BITS][idx % WORD_BITS] = (op == CMD_MARK);
					res.granted = idx;
				end
			end
			default: begin
				res.granted = idx;  // unused command: echo, no state change
			end
		endcase
		return res;
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_idle(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Mostly in range so state builds up; some anywhere to hit the range check.
	function automatic logic [IDX_W-1:0] pick_index(int act);
		if (act > 0 && $urandom_range(0, 4) != 0)
			return IDX_W'($urandom_range(0, act - 1));
		return IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
	endfunction

	function automatic logic [CFG_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return CFG_W'($urandom_range(1, 96));
		if (r < 60)
			return CFG_W'($urandom_range(97, 1023));
		if (r < 70)
			return CFG_W'(1024);
		if (r < 78)
			return CFG_W'($urandom_range(1025, 2047));
		if (r < 83)
			return '0;
		// word boundaries
		case ($urandom_range(0, 5))
			0:       return CFG_W'(31);
			1:       return CFG_W'(32);
			2:       return CFG_W'(33);
			3:       return CFG_W'(63);
			4:       return CFG_W'(64);
			default: return CFG_W'(65);
		endcase
	endfunction

	task automatic queue_request(cmd_t op, logic [IDX_W-1:0] idx);
		request_t item;
		item.op    = op;
		item.index = idx;
		request_backlog = {request_backlog, item};
		n_queued++;
	endtask

	// Random command mix; allocate-heavy so the map keeps filling.
	task automatic queue_mix(int act, int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				queue_request(CMD_ALLOC, IDX_W'($urandom));
			else if (r < 75)
				queue_request(CMD_FREE, pick_index(act));
			else if (r < 92)
				queue_request(CMD_MARK, pick_index(act));
			else
				queue_request(CMD_NOP, IDX_W'($urandom));
		end
	endtask

	// Sample at the falling edge so nothing races with the clocked processes.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || expected_grants.size() != 0 || req_ch.valid);
		repeat (4) @(negedge clk);
	endtask

	// Register writes only with the block idle.
	task automatic write_entry_limit(logic [CFG_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		entry_limit = value;
		n_cfg_writes++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: pops the backlog, holds each beat until accepted,
	// and predicts on the accepting edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		request_t nxt;
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.cmd         <= CMD_ALLOC;
			req_ch.entry_index <= '0;
			issue_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_grants = {expected_grants,
					predict_grant(cmd_t'(req_ch.cmd), req_ch.entry_index)};
				n_accepted++;
				n_by_cmd[req_ch.cmd]++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if ($urandom_range(0, 199) == 0)
					send_quiet = !send_quiet;
				if (issue_gap > 0) begin
					issue_gap--;
					req_ch.valid <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					nxt = request_backlog.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.cmd         <= nxt.op;
					req_ch.entry_index <= nxt.index;
					issue_gap = pick_idle(send_quiet);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response ready: random stalls, quiet stretches, and one long hold-off
	// that lets the block back up into the request side.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (hold_req && hold_cycles < HOLD_CYCLES) begin
			rsp_ch.ready <= 1'b0;
			hold_cycles++;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 199) == 0)
				recv_quiet = !recv_quiet;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_idle(recv_quiet);
		end
	end

	// Response checker: in-order compare against the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_checked++;
			n_by_status[rsp_ch.status]++;
			if (expected_grants.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected response beat, got index %0d status %0d",
						$time, rsp_ch.granted_index, rsp_ch.status);
			end else begin
				want = expected_grants.pop_front();
				if (rsp_ch.granted_index !== want.granted
						|| rsp_ch.status !== want.status) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: mismatch, expected %0d status %s, got %0d status %0d",
							$time, want.granted, want.status.name(),
							rsp_ch.granted_index, rsp_ch.status);
				end
			end
		end
	end

	// Watchdog: any beat on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d responses outstanding",
				$time, STALL_LIMIT, expected_grants.size());
			$display("bitmap_first_free_allocator_top test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: directed corner cases, then random phases, each under a
	// fresh entry limit written while the block is idle.
	// ------------------------------------------------------------------
	initial begin
		int act;
		int phase;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset limit: grants from zero, index extremes, redundant free/mark,
		// unused command echoes.
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_ALLOC, '1);
		queue_request(CMD_MARK,  IDX_W'(1023));
		queue_request(CMD_FREE,  IDX_W'(1023));
		queue_request(CMD_FREE,  '0);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_MARK,  '0);
		queue_request(CMD_FREE,  IDX_W'(700));
		queue_request(CMD_NOP,   IDX_W'(1023));
		queue_request(CMD_NOP,   IDX_W'(10'h2AA));

		// Zero limit: nothing valid at all.
		write_entry_limit('0);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_FREE,  '0);
		queue_request(CMD_MARK,  IDX_W'(1023));

		// Register maximum acts as the full table.
		write_entry_limit('1);
		queue_request(CMD_MARK,  IDX_W'(1023));
		queue_request(CMD_ALLOC, '0);

		// Tiny table: run out, free one, regrab it, range check just past the end.
		write_entry_limit(CFG_W'(3));
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_FREE,  IDX_W'(1));
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_MARK,  IDX_W'(3));
		queue_request(CMD_FREE,  IDX_W'(2));

		// Smallest nonzero limit, entry 0 already used: full.
		write_entry_limit(CFG_W'(1));
		queue_request(CMD_ALLOC, '0);

		phase = 0;
		while (n_queued < ITEM_TARGET) begin
			write_entry_limit(pick_limit());
			act = active_entries();
			// Long receiver hold-off while a burst is still being offered.
			if (phase == 3)
				hold_req = 1'b1;
			// Allocate storm on small tables runs them full and skips full words.
			if (act > 0 && act <= 96 && $urandom_range(0, 1) == 1)
				repeat (act + 2) queue_request(CMD_ALLOC, IDX_W'($urandom));
			queue_mix(act, $urandom_range(15, 40));
			// Sender pause until everything has drained, same limit afterwards.
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				queue_mix(act, $urandom_range(5, 15));
			end
			phase++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d commands: alloc %0d free %0d mark %0d unused %0d, %0d limit writes",
			n_accepted, n_by_cmd[CMD_ALLOC], n_by_cmd[CMD_FREE], n_by_cmd[CMD_MARK],
			n_by_cmd[CMD_NOP], n_cfg_writes);
		$display("Checked %0d responses: ok %0d, full %0d, out of range %0d, errors %0d",
			n_checked, n_by_status[ST_OK], n_by_status[ST_FULL],
			n_by_status[ST_RANGE], n_errors);
		if (n_errors == 0 && expected_grants.size() == 0)
			$display("bitmap_first_free_allocator_top test passed");
		else
			$display("bitmap_first_free_allocator_top test failed");
		$finish;
	end

endmodule
